[design/cs_pkg.sv]
package cs_pkg;

    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam int unsigned QUO_BITS = 8;

    typedef enum logic [1:0] {
        REG_IN_LOW   = 2'd0,
        REG_IN_HIGH  = 2'd1,
        REG_OUT_LOW  = 2'd2,
        REG_OUT_HIGH = 2'd3
    } cs_reg_idx_t;

    typedef struct packed {
        logic [7:0] in_low;
        logic [7:0] in_high;
        logic [7:0] out_low;
        logic [7:0] out_high;
    } cs_cfg_t;

    // segment start level, rise, offset into segment, run
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] rise;
        logic [7:0] off;
        logic [7:0] run;
    } cs_seg_t;

    typedef struct packed {
        logic [7:0]  y0;
        logic [15:0] num;
        logic [7:0]  run;
    } cs_prod_t;

    // restoring divider state: (2*num + run) / (2*run)
    typedef struct packed {
        logic [7:0]  y0;
        logic [16:0] rem;
        logic [8:0]  dvsr;
        logic [7:0]  quo;
    } cs_div_t;

endpackage

[design/cs_seg_sel.sv]
module cs_seg_sel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      pixel,
    input  cs_pkg::cs_cfg_t cfg,
    output logic            out_valid,
    output cs_pkg::cs_seg_t seg
);
    import cs_pkg::*;

    logic    curve_ok;
    cs_seg_t seg_next;
    cs_seg_t seg_reg;
    logic    valid_reg;

    assign curve_ok = (cfg.in_low < cfg.in_high) && (cfg.out_low < cfg.out_high);

    always_comb
    begin
        if (!curve_ok)
        begin
            // pass-through: zero rise gives quotient zero
            seg_next.y0   = pixel;
            seg_next.rise = 8'd0;
            seg_next.off  = 8'd0;
            seg_next.run  = 8'd1;
        end
        else if (pixel < cfg.in_low)
        begin
            seg_next.y0   = 8'd0;
            seg_next.rise = cfg.out_low;
            seg_next.off  = pixel;
            seg_next.run  = cfg.in_low;
        end
        else if (pixel <= cfg.in_high)
        begin
            seg_next.y0   = cfg.out_low;
            seg_next.rise = cfg.out_high - cfg.out_low;
            seg_next.off  = pixel - cfg.in_low;
            seg_next.run  = cfg.in_high - cfg.in_low;
        end
        else
        begin
            seg_next.y0   = cfg.out_high;
            seg_next.rise = LEVEL_MAX - cfg.out_high;
            seg_next.off  = pixel - cfg.in_high;
            seg_next.run  = LEVEL_MAX - cfg.in_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign out_valid = valid_reg;
    assign seg       = seg_reg;

endmodule

[design/cs_mul.sv]
module cs_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cs_pkg::cs_seg_t seg,
    output logic            out_valid,
    output cs_pkg::cs_div_t div
);
    import cs_pkg::*;

    cs_prod_t prod_next;
    cs_prod_t prod_reg;
    logic     prod_valid_reg;
    cs_div_t  div_next;
    cs_div_t  div_reg;
    logic     div_valid_reg;

    always_comb
    begin
        prod_next.y0  = seg.y0;
        prod_next.num = seg.rise * seg.off;
        prod_next.run = seg.run;
    end

    always_comb
    begin
        div_next.y0   = prod_reg.y0;
        div_next.rem  = {prod_reg.num, 1'b0} + {9'd0, prod_reg.run};
        div_next.dvsr = {prod_reg.run, 1'b0};
        div_next.quo  = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            div_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        div_reg  <= div_next;
    end

    assign out_valid = div_valid_reg;
    assign div       = div_reg;

endmodule

[design/cs_div_step.sv]
module cs_div_step #(
    parameter int unsigned BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cs_pkg::cs_div_t div_in,
    output logic            out_valid,
    output cs_pkg::cs_div_t div_out
);
    import cs_pkg::*;

    logic [16:0] shifted;
    logic [17:0] trial;
    cs_div_t     div_next;
    cs_div_t     div_reg;
    logic        valid_reg;

    assign shifted = {8'd0, div_in.dvsr} << BIT;
    assign trial   = {1'b0, div_in.rem} - {1'b0, shifted};

    always_comb
    begin
        div_next = div_in;
        if (!trial[17])
        begin
            div_next.rem      = trial[16:0];
            div_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;

endmodule

[design/contrast_stretch_piecewise_top.sv]
// Piecewise-linear contrast stretch, 8-bit gray pixels.
// Input: a transaction is taken on each rising edge with start high and
//   busy low. busy is held low, so one pixel can enter every cycle.
// Output: pixel_out is valid for exactly one cycle while done is high.
//   The receiver cannot stall; results appear in input order.
// Pipeline: segment select, multiply, dividend setup, eight restoring
//   divider steps of one quotient bit each, final add; the accepting edge
//   loads the first stage, and done is registered with the final add.
// Throughput: one pixel per cycle, set by the fully pipelined divider.
// Configuration: cfg_we writes cfg_data[7:0] to the register cfg_index
//   selects (0 in_low, 1 in_high, 2 out_low, 3 out_high). Write only while
//   no transaction is in flight.
// Reset: clears all valid bits and restores the identity curve
//   (in_low 0, in_high 255, out_low 0, out_high 255).
// An invalid curve (in_low >= in_high or out_low >= out_high) passes
//   pixels through unchanged.
module contrast_stretch_piecewise_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] pixel_in,
    output logic       done,
    output logic [7:0] pixel_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cs_pkg::*;

    cs_cfg_t     cfg_reg;
    logic        accept;
    logic        seg_valid;
    cs_seg_t     seg;
    logic        mul_valid;
    cs_div_t     mul_div;
    logic        step_valid [QUO_BITS+1];
    cs_div_t     step_div   [QUO_BITS+1];
    logic        done_reg;
    logic [7:0]  pixel_out_reg;
    logic [7:0]  pixel_out_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_low   <= 8'd0;
            cfg_reg.in_high  <= LEVEL_MAX;
            cfg_reg.out_low  <= 8'd0;
            cfg_reg.out_high <= LEVEL_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cs_reg_idx_t'(cfg_index))
                REG_IN_LOW:   cfg_reg.in_low   <= cfg_data;
                REG_IN_HIGH:  cfg_reg.in_high  <= cfg_data;
                REG_OUT_LOW:  cfg_reg.out_low  <= cfg_data;
                REG_OUT_HIGH: cfg_reg.out_high <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    cs_seg_sel u_seg_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel_in),
        .cfg       (cfg_reg),
        .out_valid (seg_valid),
        .seg       (seg)
    );

    cs_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .seg       (seg),
        .out_valid (mul_valid),
        .div       (mul_div)
    );

    assign step_valid[0] = mul_valid;
    assign step_div[0]   = mul_div;

    // quotient MSB first
    for (genvar g = 0; g < QUO_BITS; g++)
    begin : g_div
        cs_div_step #(
            .BIT (QUO_BITS - 1 - g)
        ) u_div_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[g]),
            .div_in    (step_div[g]),
            .out_valid (step_valid[g+1]),
            .div_out   (step_div[g+1])
        );
    end

    assign pixel_out_next = step_div[QUO_BITS].y0 + step_div[QUO_BITS].quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= step_valid[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

endmodule
